### hdl/wsp_pkg.sv
// shared types, constants and arithmetic helpers for the world to screen projection
// used by every module of the block; depends on nothing else
package wsp_pkg;

	// cordic step count, capped at the length of the arctangent table
	localparam int TRIG_ITERATIONS = 16;
	localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

	// Q2.30 constants
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	// view value limit, +-(2^33 - 1)
	localparam logic signed [36:0] VIEW_LIM = 37'sd8589934591;

	// register widths and indexes
	localparam int SCREEN_W = 14;
	localparam int CFG_AW   = 1;
	localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 1'd1;

	// queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// quotient bits produced by the divider, one per stage
	localparam int DIV_STEPS = 62;

	// one view-space point with the projection terms of its field of view
	typedef struct packed {
		logic signed [33:0] vx;
		logic signed [33:0] vy;
		logic signed [33:0] vz;
		logic [30:0]        sh;
		logic [30:0]        ch;
	} wsp_view_t;

	// arctangent of 2^-i in units of a 2^32 turn
	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] r;
		case (i)
			0:       r = 34'sd536870912;
			1:       r = 34'sd316933406;
			2:       r = 34'sd167458907;
			3:       r = 34'sd85004756;
			4:       r = 34'sd42667331;
			5:       r = 34'sd21354465;
			6:       r = 34'sd10679838;
			7:       r = 34'sd5340245;
			8:       r = 34'sd2670163;
			9:       r = 34'sd1335087;
			10:      r = 34'sd667544;
			11:      r = 34'sd333772;
			12:      r = 34'sd166886;
			13:      r = 34'sd83443;
			14:      r = 34'sd41722;
			15:      r = 34'sd20861;
			16:      r = 34'sd10430;
			17:      r = 34'sd5215;
			18:      r = 34'sd2608;
			19:      r = 34'sd1304;
			20:      r = 34'sd652;
			21:      r = 34'sd326;
			22:      r = 34'sd163;
			23:      r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clip to [-2^30, 2^30]
	function automatic logic signed [31:0] clip_q30(input logic signed [33:0] v);
		logic signed [33:0] r;
		if (v > ONE_Q30)
			r = ONE_Q30;
		else if (v < -ONE_Q30)
			r = -ONE_Q30;
		else
			r = v;
		return r[31:0];
	endfunction

	// rounded Q30 product, operands within +-2^30
	function automatic logic signed [31:0] m30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

	// saturate to 32 bit signed, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647)
			r = {1'b1, 32'h7fffffff};
		else if (v < -64'sd2147483648)
			r = {1'b1, 32'h80000000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

### hdl/wsp_cordic.sv
// pipelined rotation-mode cordic giving sine and cosine of a 32 bit binary angle
// one angle per enabled cycle; uses wsp_pkg
module wsp_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        angle,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);
	import wsp_pkg::*;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               neg;
	} cord_t;

	cord_t       st_s [0:CORDIC_STEPS];
	logic        neg_in;
	logic [31:0] ang_adj;
	logic signed [33:0] xo, yo;

	// second and third quarter turn by a half turn, negate at the end
	always_comb begin
		neg_in  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
		ang_adj = neg_in ? {~angle[31], angle[30:0]} : angle;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].x   <= CORDIC_GAIN;
			st_s[0].y   <= '0;
			st_s[0].z   <= 34'(signed'(ang_adj));
			st_s[0].neg <= neg_in;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!st_s[i].z[33]) begin
					st_s[i+1].x <= st_s[i].x - (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y + (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z - atan_turn(i);
				end else begin
					st_s[i+1].x <= st_s[i].x + (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y - (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z + atan_turn(i);
				end
				st_s[i+1].neg <= st_s[i].neg;
			end
		end
	end

	// undo the half turn and clip
	always_comb begin
		xo = st_s[CORDIC_STEPS].neg ? -st_s[CORDIC_STEPS].x : st_s[CORDIC_STEPS].x;
		yo = st_s[CORDIC_STEPS].neg ? -st_s[CORDIC_STEPS].y : st_s[CORDIC_STEPS].y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine   <= clip_q30(yo);
			cosine <= clip_q30(xo);
		end
	end

endmodule

### hdl/wsp_front.sv
// front half: takes points, builds the camera axes and forms view x, y and depth
// uses wsp_pkg and wsp_cordic; pushes one wsp_view_t per point into the queue
module wsp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       world_x,
	input  logic signed [31:0]       world_y,
	input  logic signed [31:0]       world_z,
	input  logic signed [31:0]       cam_x,
	input  logic signed [31:0]       cam_y,
	input  logic signed [31:0]       cam_z,
	input  logic [15:0]              cam_pitch,
	input  logic [15:0]              cam_yaw,
	input  logic [15:0]              cam_roll,
	input  logic [14:0]              view_angle,
	output logic                     push,
	output wsp_pkg::wsp_view_t       push_data,
	input  logic                     full
);
	import wsp_pkg::*;

	localparam int FRONT_LAST = CORDIC_STEPS + 7;
	localparam int D_TAP      = CORDIC_STEPS + 5;

	typedef logic signed [32:0] off_t [0:2];

	logic              en;
	logic [FRONT_LAST:0] vld_q;

	off_t              dd_s [0:D_TAP];
	logic [15:0]       pitch_s0, yaw_s0, roll_s0;
	logic [14:0]       half_s0;

	logic signed [31:0] sp, cp, sy, cy, sr, cr, sh, ch;

	logic signed [31:0] srsp_s1, crsp_s1, cpcy_s1, cpsy_s1, crsy_s1, crcy_s1;
	logic signed [31:0] srcp_s1, srsy_s1, srcy_s1, crcp_s1, sp_s1, cy_s1, sy_s1;
	logic [30:0]        sh_s1, ch_s1;

	logic signed [31:0] srspcy_s2, srspsy_s2, crspcy_s2, crspsy_s2;
	logic signed [31:0] cpcy_s2, cpsy_s2, sp_s2, crsy_s2, crcy_s2;
	logic signed [31:0] srcp_s2, srsy_s2, srcy_s2, crcp_s2;
	logic [30:0]        sh_s2, ch_s2;

	logic signed [31:0] axis_s3 [0:8];
	logic [30:0]        sh_s3, ch_s3;

	logic signed [50:0] prod_s4 [0:8];
	logic [30:0]        sh_s4, ch_s4;

	logic signed [33:0] view_s5 [0:2];
	logic [30:0]        sh_s5, ch_s5;

	// whole front moves together unless its last stage is blocked by a full queue
	assign en       = !vld_q[FRONT_LAST] || !full;
	assign in_ready = en;
	assign push     = vld_q[FRONT_LAST] && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FRONT_LAST-1:0], in_valid};
		end
	end

	// input register: offset from camera to point and the angles
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0][0] <= 33'(world_x) - 33'(cam_x);
			dd_s[0][1] <= 33'(world_y) - 33'(cam_y);
			dd_s[0][2] <= 33'(world_z) - 33'(cam_z);
			pitch_s0   <= cam_pitch;
			yaw_s0     <= cam_yaw;
			roll_s0    <= cam_roll;
			half_s0    <= view_angle;
		end
	end

	// offset waits alongside the trig and axis stages
	for (genvar k = 1; k <= D_TAP; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en)
				dd_s[k] <= dd_s[k-1];
		end
	end

	wsp_cordic u_pitch (.clk(clk), .en(en), .angle({pitch_s0, 16'b0}), .sine(sp), .cosine(cp));
	wsp_cordic u_yaw   (.clk(clk), .en(en), .angle({yaw_s0, 16'b0}),   .sine(sy), .cosine(cy));
	wsp_cordic u_roll  (.clk(clk), .en(en), .angle({roll_s0, 16'b0}),  .sine(sr), .cosine(cr));
	wsp_cordic u_half  (.clk(clk), .en(en), .angle({2'b0, half_s0, 15'b0}),
		.sine(sh), .cosine(ch));

	// first products of the rotation matrix
	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= m30(sr, sp);
			crsp_s1 <= m30(cr, sp);
			cpcy_s1 <= m30(cp, cy);
			cpsy_s1 <= m30(cp, sy);
			crsy_s1 <= m30(cr, sy);
			crcy_s1 <= m30(cr, cy);
			srcp_s1 <= m30(sr, cp);
			srsy_s1 <= m30(sr, sy);
			srcy_s1 <= m30(cy, sr);
			crcp_s1 <= m30(cr, cp);
			sp_s1   <= sp;
			cy_s1   <= cy;
			sy_s1   <= sy;
			sh_s1   <= (sh < 32'sd1) ? 31'd1 : sh[30:0];
			ch_s1   <= ch[31] ? 31'd0 : ch[30:0];
		end
	end

	// second products
	always_ff @(posedge clk) begin
		if (en) begin
			srspcy_s2 <= m30(srsp_s1, cy_s1);
			srspsy_s2 <= m30(srsp_s1, sy_s1);
			crspcy_s2 <= m30(crsp_s1, cy_s1);
			crspsy_s2 <= m30(crsp_s1, sy_s1);
			cpcy_s2   <= cpcy_s1;
			cpsy_s2   <= cpsy_s1;
			sp_s2     <= sp_s1;
			crsy_s2   <= crsy_s1;
			crcy_s2   <= crcy_s1;
			srcp_s2   <= srcp_s1;
			srsy_s2   <= srsy_s1;
			srcy_s2   <= srcy_s1;
			crcp_s2   <= crcp_s1;
			sh_s2     <= sh_s1;
			ch_s2     <= ch_s1;
		end
	end

	// camera axes: forward, right, up, each element clipped
	always_ff @(posedge clk) begin
		if (en) begin
			axis_s3[0] <= clip_q30(34'(cpcy_s2));
			axis_s3[1] <= clip_q30(34'(cpsy_s2));
			axis_s3[2] <= clip_q30(34'(sp_s2));
			axis_s3[3] <= clip_q30(34'(srspcy_s2) - 34'(crsy_s2));
			axis_s3[4] <= clip_q30(34'(srspsy_s2) + 34'(crcy_s2));
			axis_s3[5] <= clip_q30(-34'(srcp_s2));
			axis_s3[6] <= clip_q30(-(34'(crspcy_s2) + 34'(srsy_s2)));
			axis_s3[7] <= clip_q30(34'(srcy_s2) - 34'(crspsy_s2));
			axis_s3[8] <= clip_q30(34'(crcp_s2));
			sh_s3      <= sh_s2;
			ch_s3      <= ch_s2;
		end
	end

	// dot product terms, each shifted down by 14
	for (genvar k = 0; k < 9; k++) begin : g_term
		logic signed [64:0] p;
		assign p = 65'(dd_s[D_TAP][k % 3]) * 65'(axis_s3[k]);
		always_ff @(posedge clk) begin
			if (en)
				prod_s4[k] <= p[64:14];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s4 <= sh_s3;
			ch_s4 <= ch_s3;
		end
	end

	// sums back to Q8 and clipped; view x from right, y from up, depth from forward
	for (genvar v = 0; v < 3; v++) begin : g_sum
		localparam int A = (v == 2) ? 0 : (v + 1) * 3;
		logic signed [52:0] s;
		logic signed [36:0] r;
		logic signed [36:0] c;
		always_comb begin
			s = 53'(prod_s4[A]) + 53'(prod_s4[A+1]) + 53'(prod_s4[A+2]) + 53'sd32768;
			r = s[52:16];
			if (r > VIEW_LIM)
				c = VIEW_LIM;
			else if (r < -VIEW_LIM)
				c = -VIEW_LIM;
			else
				c = r;
		end
		always_ff @(posedge clk) begin
			if (en)
				view_s5[v] <= c[33:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s5 <= sh_s4;
			ch_s5 <= ch_s4;
		end
	end

	always_comb begin
		push_data.vx = view_s5[0];
		push_data.vy = view_s5[1];
		push_data.vz = view_s5[2];
		push_data.sh = sh_s5;
		push_data.ch = ch_s5;
	end

endmodule

### hdl/wsp_fifo.sv
// short queue of view-space points between the front and back halves
// first word falls through; uses wsp_pkg for the entry type and depth
module wsp_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wsp_pkg::wsp_view_t push_data,
	output logic               full,
	output logic               valid,
	output wsp_pkg::wsp_view_t pop_data,
	input  logic               pop
);
	import wsp_pkg::*;

	wsp_view_t           mem_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (!push && pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### hdl/wsp_back.sv
// back half: perspective divide of view x and y by depth, centering and saturation
// pipelined restoring divider, one quotient bit per stage; uses wsp_pkg
module wsp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	input  wsp_pkg::wsp_view_t    pop_data,
	output logic                  pop,
	input  logic [wsp_pkg::SCREEN_W-1:0] screen_width,
	input  logic [wsp_pkg::SCREEN_W-1:0] screen_height,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    screen_x,
	output logic signed [31:0]    screen_y,
	output logic signed [31:0]    depth,
	output logic                  saturated
);
	import wsp_pkg::*;

	typedef struct packed {
		logic [62:0] rem;
		logic [61:0] dq;
	} div_t;

	typedef struct packed {
		logic [62:0]        uc;
		logic               negx;
		logic               negy;
		logic               capx;
		logic               capy;
		logic               zerox;
		logic               zeroy;
		logic signed [33:0] vz;
	} meta_t;

	logic        en;
	logic        v_s1, v_s2;
	logic [DIV_STEPS:0] v_div_s;
	logic        out_valid_q;

	logic [20:0] cx, cy;
	logic [32:0] ux_in, uy_in, uz_in;

	logic [32:0]        ux_s1, uy_s1;
	logic [50:0]        scale_s1;
	logic [62:0]        uc_s1;
	logic               negx_s1, negy_s1;
	logic signed [33:0] vz_s1;

	logic [58:0]        plx_s2, ply_s2;
	logic [57:0]        phx_s2, phy_s2;
	logic [62:0]        uc_s2;
	logic               negx_s2, negy_s2;
	logic signed [33:0] vz_s2;

	logic [83:0] px, py;

	div_t  dx_s [0:DIV_STEPS];
	div_t  dy_s [0:DIV_STEPS];
	meta_t mt_s [0:DIV_STEPS];

	logic [62:0]        magx, magy;
	logic signed [63:0] qx, qy;
	logic [32:0]        rx, ry, rz;

	// back pipeline moves whenever the output register can take a result
	assign en        = !out_valid_q || out_ready;
	assign pop       = valid && en;
	assign out_valid = out_valid_q;

	assign cx = {screen_width, 7'b0};
	assign cy = {screen_height, 7'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_div_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= valid;
			v_s2        <= v_s1;
			v_div_s     <= {v_div_s[DIV_STEPS-1:0], v_s2};
			out_valid_q <= v_div_s[DIV_STEPS];
		end
	end

	// magnitudes, focal scale and divisor
	always_comb begin
		ux_in = pop_data.vx[33] ? 33'(-pop_data.vx) : pop_data.vx[32:0];
		uy_in = pop_data.vy[33] ? 33'(-pop_data.vy) : pop_data.vy[32:0];
		uz_in = pop_data.vz[33] ? 33'(-pop_data.vz) : pop_data.vz[32:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1    <= ux_in;
			uy_s1    <= uy_in;
			scale_s1 <= 51'(cx) * 51'(pop_data.ch);
			uc_s1    <= 63'(uz_in) * 63'(pop_data.sh);
			negx_s1  <= pop_data.vx[33] ^ pop_data.vz[33];
			negy_s1  <= pop_data.vy[33] ^ pop_data.vz[33];
			vz_s1    <= pop_data.vz;
		end
	end

	// numerator products split over the focal scale
	always_ff @(posedge clk) begin
		if (en) begin
			plx_s2  <= ux_s1 * scale_s1[25:0];
			phx_s2  <= ux_s1 * scale_s1[50:26];
			ply_s2  <= uy_s1 * scale_s1[25:0];
			phy_s2  <= uy_s1 * scale_s1[50:26];
			uc_s2   <= uc_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			vz_s2   <= vz_s1;
		end
	end

	// full numerators, overflow and zero checks, divider load
	always_comb begin
		px = 84'(plx_s2) + (84'(phx_s2) << 26);
		py = 84'(ply_s2) + (84'(phy_s2) << 26);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s[0].rem    <= 63'(px[83:62]);
			dx_s[0].dq     <= px[61:0];
			dy_s[0].rem    <= 63'(py[83:62]);
			dy_s[0].dq     <= py[61:0];
			mt_s[0].uc     <= uc_s2;
			mt_s[0].negx   <= negx_s2;
			mt_s[0].negy   <= negy_s2;
			mt_s[0].capx   <= 63'(px[83:62]) >= uc_s2;
			mt_s[0].capy   <= 63'(py[83:62]) >= uc_s2;
			mt_s[0].zerox  <= px == '0;
			mt_s[0].zeroy  <= py == '0;
			mt_s[0].vz     <= vz_s2;
		end
	end

	// restoring divide, both quotients share the divisor
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [63:0] tx, ty;
		logic        gex, gey;
		logic [63:0] sx, sy;
		always_comb begin
			tx  = {dx_s[j].rem, dx_s[j].dq[61]};
			ty  = {dy_s[j].rem, dy_s[j].dq[61]};
			gex = tx >= {1'b0, mt_s[j].uc};
			gey = ty >= {1'b0, mt_s[j].uc};
			sx  = gex ? tx - {1'b0, mt_s[j].uc} : tx;
			sy  = gey ? ty - {1'b0, mt_s[j].uc} : ty;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dx_s[j+1].rem <= sx[62:0];
				dx_s[j+1].dq  <= {dx_s[j].dq[60:0], gex};
				dy_s[j+1].rem <= sy[62:0];
				dy_s[j+1].dq  <= {dy_s[j].dq[60:0], gey};
				mt_s[j+1]     <= mt_s[j];
			end
		end
	end

	// apply cap, zero and sign, then center and saturate
	always_comb begin
		if (mt_s[DIV_STEPS].zerox)
			magx = '0;
		else if (mt_s[DIV_STEPS].capx)
			magx = 63'(1) << 62;
		else
			magx = 63'(dx_s[DIV_STEPS].dq);
		if (mt_s[DIV_STEPS].zeroy)
			magy = '0;
		else if (mt_s[DIV_STEPS].capy)
			magy = 63'(1) << 62;
		else
			magy = 63'(dy_s[DIV_STEPS].dq);
		qx = mt_s[DIV_STEPS].negx ? -64'(magx) : 64'(magx);
		qy = mt_s[DIV_STEPS].negy ? -64'(magy) : 64'(magy);
		rx = sat32(64'(cx) + qx);
		ry = sat32(64'(cy) - qy);
		rz = sat32(64'(mt_s[DIV_STEPS].vz));
	end

	always_ff @(posedge clk) begin
		if (en && v_div_s[DIV_STEPS]) begin
			screen_x  <= rx[31:0];
			screen_y  <= ry[31:0];
			depth     <= rz[31:0];
			saturated <= rx[32] || ry[32] || rz[32] || (mt_s[DIV_STEPS].vz == '0);
		end
	end

endmodule

### hdl/world_to_screen_projection.sv
// World to screen perspective projection, top level.
// Input channel (in_valid/in_ready) carries one world point and camera pose per
// transfer; output channel (out_valid/out_ready) returns screen x, y, depth and a
// saturation flag per transfer, in the order the points arrived.
// Registers screen_width (index 0) and screen_height (index 1) are written through
// cfg_wen/cfg_addr/cfg_wdata; the user must write them only while no point is in
// flight, as the block itself does not enforce it.
// Throughput: one point per cycle while out_ready is high. Latency is set by the
// cordic pipeline in the front and the 62 stage divider in the back.
// The front and back halves are joined by a four entry queue; when out_ready is
// low the back half holds, the queue fills, then the front half holds and in_ready
// drops. Items are never dropped or repeated.
// Reset (arst_n low) empties every pipeline and the queue and sets the registers
// to 1920 by 1080; no clearing pass is needed afterwards.
// Depends on wsp_pkg, wsp_front, wsp_fifo, wsp_back and wsp_cordic.
module world_to_screen_projection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [wsp_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [wsp_pkg::SCREEN_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            world_x,
	input  logic signed [31:0]            world_y,
	input  logic signed [31:0]            world_z,
	input  logic signed [31:0]            cam_x,
	input  logic signed [31:0]            cam_y,
	input  logic signed [31:0]            cam_z,
	input  logic [15:0]                   cam_pitch,
	input  logic [15:0]                   cam_yaw,
	input  logic [15:0]                   cam_roll,
	input  logic [14:0]                   view_angle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            screen_x,
	output logic signed [31:0]            screen_y,
	output logic signed [31:0]            depth,
	output logic                          saturated
);
	import wsp_pkg::*;

	logic [SCREEN_W-1:0] screen_width_q, screen_height_q;
	logic                push, full, q_valid, pop;
	wsp_view_t           push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_W'(1920);
			screen_height_q <= SCREEN_W'(1080);
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	wsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.world_x    (world_x),
		.world_y    (world_y),
		.world_z    (world_z),
		.cam_x      (cam_x),
		.cam_y      (cam_y),
		.cam_z      (cam_z),
		.cam_pitch  (cam_pitch),
		.cam_yaw    (cam_yaw),
		.cam_roll   (cam_roll),
		.view_angle (view_angle),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	wsp_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.valid     (q_valid),
		.pop_data  (pop_data),
		.pop       (pop)
	);

	wsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (q_valid),
		.pop_data      (pop_data),
		.pop           (pop),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.depth         (depth),
		.saturated     (saturated)
	);

endmodule

### bench/tb_world_to_screen_projection.sv
// self-checking bench for the world to screen projection block
// predicts each point with a local fixed-point model; depends on wsp_pkg and the block
`timescale 1ns / 100ps

module tb_world_to_screen_projection;
	import wsp_pkg::*;

	localparam longint Q30       = 64'sd1073741824;
	localparam longint VLIM      = 64'sd8589934591;
	localparam int     LATENCY   = 100;
	localparam int     N_RANDOM  = 900;
	localparam longint MAX_CYCLES = 2000000;

	typedef struct {
		logic signed [31:0] wx, wy, wz, cx, cy, cz;
		logic [15:0]        pitch, yaw, roll;
		logic [14:0]        fov;
	} point_t;

	typedef struct {
		logic signed [31:0] sx, sy, dz;
		logic               sat;
	} proj_t;

	// directed row: point, whether a typed result applies, and that result
	typedef struct {
		point_t p;
		bit     typed;
		proj_t  r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = REG_SCREEN_WIDTH;
	logic [SCREEN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic signed [31:0] cam_x = '0, cam_y = '0, cam_z = '0;
	logic [15:0] cam_pitch = '0, cam_yaw = '0, cam_roll = '0;
	logic [14:0] view_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] screen_x, screen_y, depth;
	logic saturated;

	longint width_q = 1920, height_q = 1080;
	proj_t  pending[$];
	int     n_fail = 0, n_sent = 0, n_got = 0, n_sat = 0;
	longint cycle = 0;
	bit     long_hold = 1'b0;

	always #1 clk = ~clk;

	world_to_screen_projection u_top (.*);

	function automatic longint sar(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint mulq(longint a, longint b);
		return sar(a * b + 64'sd536870912, 30);
	endfunction

	// cordic sine and cosine of a 32-bit binary angle
	function automatic void trig(input logic [31:0] ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip)
			ang = ang + 32'h80000000;
		x = 652032874;
		y = 0;
		z = longint'(signed'(ang));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = sar(y, i);
			dy = sar(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = clamp(y, -Q30, Q30);
		c = clamp(x, -Q30, Q30);
	endfunction

	function automatic logic signed [127:0] clamp128(logic signed [127:0] v,
		logic signed [127:0] cap);
		return v > cap ? cap : (v < -cap ? -cap : v);
	endfunction

	// a*b/c toward zero with magnitude capped at 2^62
	function automatic longint scaled_quotient(longint a, longint b, longint c);
		logic signed [127:0] num, q, cap;
		if (a == 0 || b == 0)
			return 0;
		cap = 128'sd1 <<< 62;
		num = 128'(a) * 128'(b);
		if (c == 0)
			q = num < 0 ? -cap : cap;
		else
			q = num / 128'(c);
		return longint'(clamp128(q, cap));
	endfunction

	function automatic longint view_dot(longint d[3], longint a[3]);
		longint sum = 0;
		for (int i = 0; i < 3; i++)
			sum += sar(d[i] * a[i], 14);
		return clamp(sar(sum + 64'sd32768, 16), -VLIM, VLIM);
	endfunction

	function automatic longint sat_word(longint v, ref bit flag);
		longint r;
		r = clamp(v, -64'sd2147483648, 64'sd2147483647);
		if (r != v)
			flag = 1'b1;
		return r;
	endfunction

	function automatic proj_t project(point_t p);
		longint sp, cp, sy, cy, sr, cr, sh, ch, srsp, crsp;
		longint ax[3], ay[3], az[3], d[3];
		longint vx, vy, vz, ccx, ccy, scl, den, qx, qy;
		bit flag;
		proj_t r;
		flag = 1'b0;
		d[0] = longint'(p.wx) - longint'(p.cx);
		d[1] = longint'(p.wy) - longint'(p.cy);
		d[2] = longint'(p.wz) - longint'(p.cz);
		trig({p.pitch, 16'h0}, sp, cp);
		trig({p.yaw, 16'h0}, sy, cy);
		trig({p.roll, 16'h0}, sr, cr);
		trig({2'b0, p.fov, 15'h0}, sh, ch);
		srsp = mulq(sr, sp);
		crsp = mulq(cr, sp);
		ax[0] = mulq(cp, cy);
		ax[1] = mulq(cp, sy);
		ax[2] = sp;
		ay[0] = mulq(srsp, cy) - mulq(cr, sy);
		ay[1] = mulq(srsp, sy) + mulq(cr, cy);
		ay[2] = -mulq(sr, cp);
		az[0] = -(mulq(crsp, cy) + mulq(sr, sy));
		az[1] = mulq(cy, sr) - mulq(crsp, sy);
		az[2] = mulq(cr, cp);
		for (int i = 0; i < 3; i++) begin
			ax[i] = clamp(ax[i], -Q30, Q30);
			ay[i] = clamp(ay[i], -Q30, Q30);
			az[i] = clamp(az[i], -Q30, Q30);
		end
		vx = view_dot(d, ay);
		vy = view_dot(d, az);
		vz = view_dot(d, ax);
		sh = clamp(sh, 1, Q30);
		ch = clamp(ch, 0, Q30);
		ccx = width_q << 7;
		ccy = height_q << 7;
		scl = ccx * ch;
		den = vz * sh;
		qx = scaled_quotient(vx, scl, den);
		qy = scaled_quotient(vy, scl, den);
		if (vz == 0)
			flag = 1'b1;
		r.sx = 32'(sat_word(ccx + qx, flag));
		r.sy = 32'(sat_word(ccy - qy, flag));
		r.dz = 32'(sat_word(vz, flag));
		r.sat = flag;
		return r;
	endfunction

	function automatic point_t mk(longint wx, longint wy, longint wz, longint cx,
		longint cy, longint cz, int pitch, int yaw, int roll, int fov);
		point_t p;
		p.wx = 32'(wx); p.wy = 32'(wy); p.wz = 32'(wz);
		p.cx = 32'(cx); p.cy = 32'(cy); p.cz = 32'(cz);
		p.pitch = 16'(pitch); p.yaw = 16'(yaw); p.roll = 16'(roll);
		p.fov = 15'(fov);
		return p;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return int'($urandom());
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return int'($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	// mostly plausible scenes: point near camera, moderate fov, some noise
	function automatic point_t rand_point();
		point_t p;
		p.cx = rand_coord(); p.cy = rand_coord(); p.cz = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			p.wx = p.cx + int'($urandom_range(0, 400000)) - 200000;
			p.wy = p.cy + int'($urandom_range(0, 400000)) - 200000;
			p.wz = p.cz + int'($urandom_range(0, 400000)) - 200000;
		end else begin
			p.wx = rand_coord(); p.wy = rand_coord(); p.wz = rand_coord();
		end
		p.pitch = 16'($urandom()); p.yaw = 16'($urandom()); p.roll = 16'($urandom());
		p.fov = $urandom_range(0, 7) == 0 ? 15'($urandom()) : 15'($urandom_range(4000, 24000));
		if (p.fov == 0)
			p.fov = 1;
		return p;
	endfunction

	// one register write, then a settle wait so back to back writes never collide
	task automatic reg_write(logic [CFG_AW-1:0] idx, int value);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= SCREEN_W'(value);
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			width_q = value & 16'h3fff;
		else
			height_q = value & 16'h3fff;
		@(posedge clk);
	endtask

	// one transfer on the input channel
	task automatic send_point(point_t p);
		world_x <= p.wx; world_y <= p.wy; world_z <= p.wz;
		cam_x <= p.cx; cam_y <= p.cy; cam_z <= p.cz;
		cam_pitch <= p.pitch; cam_yaw <= p.yaw; cam_roll <= p.roll;
		view_angle <= p.fov;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending.push_back(project(p));
		n_sent++;
	endtask

	// random gap after a burst; valid only drops when a gap is taken
	task automatic maybe_gap(ref int burst);
		int gap;
		if (--burst > 0)
			return;
		burst = $urandom_range(1, 20);
		gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int burst;
		burst = 1;
		for (int i = 0; i < count; i++) begin
			send_point(rand_point());
			maybe_gap(burst);
		end
		drain();
	endtask

	// receiver stall pattern, with one long hold-off
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 1'b0;
		else
			case ((cycle >> 6) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 3) != 0;
				2: out_ready <= $urandom_range(0, 1);
				default: out_ready <= $urandom_range(0, 7) == 0;
			endcase
	end

	// output checker
	always @(posedge clk) begin
		proj_t e;
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (saturated)
				n_sat++;
			if (pending.size() == 0) begin
				$error("unexpected transfer: screen_x %0d", screen_x);
				n_fail++;
			end else begin
				e = pending.pop_front();
				if (screen_x !== e.sx) begin
					$error("screen_x expected %0d actual %0d", e.sx, screen_x);
					n_fail++;
				end
				if (screen_y !== e.sy) begin
					$error("screen_y expected %0d actual %0d", e.sy, screen_y);
					n_fail++;
				end
				if (depth !== e.dz) begin
					$error("depth expected %0d actual %0d", e.dz, depth);
					n_fail++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, saturated);
					n_fail++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		proj_t got;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows are zero-offset points, depth zero at the centre
		rw.typed = 1'b1;
		rw.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 16384);
		rw.r = '{32'sd245760, 32'sd138240, 32'sd0, 1'b1};
		rows.push_back(rw);
		rw.p = mk(-2147483648, 2147483647, 0, -2147483648, 2147483647, 0,
			65535, 65535, 65535, 32767);
		rows.push_back(rw);
		rw.typed = 1'b0;
		rw.p = mk(25600, 0, 0, 0, 0, 0, 0, 0, 0, 16384); rows.push_back(rw);
		rw.p = mk(25600, 2560, 5120, 0, 0, 0, 0, 0, 0, 16384); rows.push_back(rw);
		rw.p = mk(-25600, 2560, 5120, 0, 0, 0, 0, 0, 0, 16384); rows.push_back(rw);
		rw.p = mk(25600, 2560, 5120, 0, 0, 0, 0, 0, 0, 1); rows.push_back(rw);
		rw.p = mk(25600, 2560, 5120, 0, 0, 0, 0, 0, 0, 32767); rows.push_back(rw);
		rw.p = mk(2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
			-2147483648, 0, 0, 0, 16384); rows.push_back(rw);
		rw.p = mk(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647,
			2147483647, 65535, 65535, 65535, 32767); rows.push_back(rw);
		rw.p = mk(0, 25600, 0, 0, 0, 0, 16384, 0, 0, 16384); rows.push_back(rw);
		rw.p = mk(0, 25600, 0, 0, 0, 0, 0, 16384, 0, 16384); rows.push_back(rw);
		rw.p = mk(1000, 2000, 3000, 0, 0, 0, 0, 0, 16384, 10000); rows.push_back(rw);
		rw.p = mk(1000, 2000, 3000, 0, 0, 0, 32768, 32768, 32768, 10000); rows.push_back(rw);
		rw.p = mk(1000, 2000, 3000, 0, 0, 0, 49152, 49152, 49152, 10000); rows.push_back(rw);
		rw.p = mk(1000, 2000, 3000, 500, 500, 500, 21845, 43690, 12345, 21845);
		rows.push_back(rw);
		rw.p = mk(0, 0, 25600, 0, 0, 0, 0, 0, 0, 16384); rows.push_back(rw);
		foreach (rows[i]) begin
			send_point(rows[i].p);
			if (rows[i].typed) begin
				got = pending[$];
				if (got.sx !== rows[i].r.sx || got.sy !== rows[i].r.sy ||
					got.dz !== rows[i].r.dz || got.sat !== rows[i].r.sat) begin
					$error("typed row %0d: predictor disagrees with table", i);
					n_fail++;
				end
				pending[$] = rows[i].r;
			end
		end
		drain();

		// screen size extremes, zero included
		reg_write(REG_SCREEN_WIDTH, 8192);
		reg_write(REG_SCREEN_HEIGHT, 1);
		random_phase(150);
		reg_write(REG_SCREEN_WIDTH, 0);
		reg_write(REG_SCREEN_HEIGHT, 0);
		random_phase(60);
		reg_write(REG_SCREEN_WIDTH, 1);
		reg_write(REG_SCREEN_HEIGHT, 16383);
		random_phase(90);

		// long receiver hold so the block backs up into its input
		reg_write(REG_SCREEN_WIDTH, 1280);
		reg_write(REG_SCREEN_HEIGHT, 720);
		long_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 200; i++)
					send_point(rand_point());
			end
		join
		drain();

		reg_write(REG_SCREEN_WIDTH, 1920);
		reg_write(REG_SCREEN_HEIGHT, 1080);
		random_phase(N_RANDOM - 500);

		$display("covered %0d points in, %0d results out, %0d saturated, five screen sizes",
			n_sent, n_got, n_sat);
		if (n_fail == 0 && pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### world_to_screen_projection.f
hdl/wsp_pkg.sv
hdl/wsp_cordic.sv
hdl/wsp_front.sv
hdl/wsp_fifo.sv
hdl/wsp_back.sv
hdl/world_to_screen_projection.sv
bench/tb_world_to_screen_projection.sv
